>>> rtl/aafsp_pkg.sv
// shared types and constants for the aligned first-fit segment placer
package aafsp_pkg;

  localparam int ADDR_W = 40;
  localparam int LEN_W  = 32;
  localparam int SHIFT_W = 5;
  // working width for candidate and end addresses (base + length + rounding)
  localparam int CALC_W = 42;
  localparam logic [CALC_W-1:0] ADDR_TOP = CALC_W'(64'h100_0000_0000);

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT    = 2'd2;

  localparam logic OP_FIRST_FIT = 1'b0;
  localparam logic OP_IDENTITY  = 1'b1;

  typedef enum logic [2:0] {
    STATUS_PLACED   = 3'd0,
    STATUS_ZERO_LEN = 3'd1,
    STATUS_NO_SPACE = 3'd2,
    STATUS_OVERLAP  = 3'd3,
    STATUS_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic                op;
    logic [LEN_W-1:0]    seg_length;
    logic [SHIFT_W-1:0]  align_shift;
    logic [ADDR_W-1:0]   ident_base;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   placed_base;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  length;
  } entry_t;

endpackage

>>> rtl/aligned_first_fit_segment_placer.sv
// top level: segment table kept sorted by base, walked by a shared adder under a sequencer
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall  | in_item (op, seg_length, align_shift, ident_base)
//  out_    | output    | out_valid / out_stall| out_item (status, placed_base)
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// zero length or full table: the item goes from accept straight to the final step, which loads the result register.
// first fit: each gap tried takes a read, a round and add, and a compare; each stored
//   segment above the slot is then moved up one place to open it.
// identity: each stored segment is checked for overlap, and those above the slot are moved up as for first fit.
// reset (synchronous) empties the table and loads the register reset values.
// a finished result waits in the output register while out_stall is high; the
//   next item is taken meanwhile and holds in its last step until the register frees.
module aligned_first_fit_segment_placer #(
  parameter int MAX_SEGMENTS = aafsp_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  aafsp_pkg::in_item_t                    in_item,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output aafsp_pkg::out_item_t                   out_item,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [aafsp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aafsp_pkg::ADDR_W-1:0]           cfg_data
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int CW    = aafsp_pkg::CALC_W;
  localparam int AW    = aafsp_pkg::ADDR_W;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_PREP = 9'b000000010,
    ST_RD   = 9'b000000100,
    ST_END  = 9'b000001000,
    ST_CMP  = 9'b000010000,
    ST_SHR  = 9'b000100000,
    ST_SHW  = 9'b001000000,
    ST_WNEW = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  aafsp_pkg::in_item_t  item_r, item_nxt;
  aafsp_pkg::status_t   status_r, status_nxt;
  logic [AW-1:0]        where_r, where_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [CW-1:0]        prev_r, prev_nxt;
  logic [CW-1:0]        cand_r, cand_nxt;
  logic [CW-1:0]        end_r, end_nxt;
  logic [CW-1:0]        lim_r, lim_nxt;

  logic [AW-1:0]                  region_base_r;
  logic [AW-1:0]                  region_length_r;
  logic [aafsp_pkg::SHIFT_W-1:0]  page_shift_r;

  logic                 out_valid_r, out_valid_nxt;
  aafsp_pkg::out_item_t out_item_r, out_item_nxt;

  // segment table, kept in ascending base order
  aafsp_pkg::entry_t    mem [MAX_SEGMENTS];
  aafsp_pkg::entry_t    rd_q;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  aafsp_pkg::entry_t    wr_data;

  // shared adder
  logic [CW-1:0] add_a, add_b, add_y;

  logic [aafsp_pkg::SHIFT_W-1:0] sh_c;
  logic [CW-1:0]                 mask_c;
  logic [CW-1:0]                 rd_base_x, rd_end_lim, ib_x, len_x;
  logic                          is_ident, accept, fit, overlap, out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign is_ident  = (item_r.op == aafsp_pkg::OP_IDENTITY);
  assign rd_base_x = CW'(rd_q.base);
  assign ib_x      = CW'(item_r.ident_base);
  assign len_x     = CW'(item_r.seg_length);
  assign sh_c      = (item_r.align_shift > page_shift_r) ? item_r.align_shift : page_shift_r;
  // the very first segment goes at the region base with no rounding
  assign mask_c    = (cnt_r == '0) ? '0 : ((CW'(1) << sh_c) - CW'(1));
  assign add_y     = add_a + add_b;

  // after the last stored segment the gap ends at the region end
  assign rd_end_lim = (idx_r == cnt_r) ? lim_r : rd_base_x;
  assign fit        = (end_r <= rd_end_lim) && (end_r <= aafsp_pkg::ADDR_TOP);
  // prev_r holds the stored segment's end, lim_r the new segment's end
  assign overlap    = (ib_x == rd_base_x)
                   || ((ib_x < rd_base_x) && (lim_r > rd_base_x))
                   || ((ib_x > rd_base_x) && (prev_r > ib_x));

  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_r)
      ST_PREP: begin
        if (is_ident) begin
          add_a = ib_x;
          add_b = len_x;
        end else begin
          add_a = CW'(region_base_r);
          add_b = CW'(region_length_r);
        end
      end
      ST_RD: begin
        add_a = prev_r;
        add_b = mask_c;
      end
      ST_END: begin
        if (is_ident) begin
          add_a = rd_base_x;
          add_b = CW'(rd_q.length);
        end else begin
          add_a = cand_r;
          add_b = len_x;
        end
      end
      ST_CMP: begin
        add_a = rd_base_x;
        add_b = CW'(rd_q.length);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    status_nxt    = status_r;
    where_nxt     = where_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    prev_nxt      = prev_r;
    cand_nxt      = cand_r;
    end_nxt       = end_r;
    lim_nxt       = lim_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en         = 1'b0;
    rd_addr       = idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = k_r[IDX_W-1:0];
    wr_data       = rd_q;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_item;
          where_nxt = '0;
          idx_nxt   = '0;
          pos_nxt   = '0;
          if (in_item.seg_length == '0) begin
            status_nxt = aafsp_pkg::STATUS_ZERO_LEN;
            state_nxt  = ST_FIN;
          end else if (cnt_r == CNT_W'(MAX_SEGMENTS)) begin
            status_nxt = aafsp_pkg::STATUS_FULL;
            state_nxt  = ST_FIN;
          end else begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        lim_nxt   = add_y;
        prev_nxt  = CW'(region_base_r);
        state_nxt = ST_RD;
      end
      ST_RD: begin
        if (is_ident && (idx_r == cnt_r)) begin
          status_nxt = aafsp_pkg::STATUS_PLACED;
          where_nxt  = item_r.ident_base;
          k_nxt      = cnt_r;
          state_nxt  = ST_SHR;
        end else begin
          rd_en     = (idx_r != cnt_r);
          cand_nxt  = add_y & ~mask_c;
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (is_ident) begin
          prev_nxt = add_y;
        end else begin
          end_nxt = add_y;
        end
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (is_ident) begin
          if (overlap) begin
            status_nxt = aafsp_pkg::STATUS_OVERLAP;
            state_nxt  = ST_FIN;
          end else begin
            if (ib_x > rd_base_x) begin
              pos_nxt = idx_r + CNT_W'(1);
            end
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_RD;
          end
        end else if (fit) begin
          status_nxt = aafsp_pkg::STATUS_PLACED;
          where_nxt  = cand_r[AW-1:0];
          pos_nxt    = idx_r;
          k_nxt      = cnt_r;
          state_nxt  = ST_SHR;
        end else if (idx_r == cnt_r) begin
          status_nxt = aafsp_pkg::STATUS_NO_SPACE;
          state_nxt  = ST_FIN;
        end else begin
          prev_nxt  = add_y;
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_SHR: begin
        if (k_r == pos_r) begin
          state_nxt = ST_WNEW;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(k_r - CNT_W'(1));
          state_nxt = ST_SHW;
        end
      end
      ST_SHW: begin
        // move one segment up a slot
        wr_en     = 1'b1;
        wr_addr   = k_r[IDX_W-1:0];
        wr_data   = rd_q;
        k_nxt     = k_r - CNT_W'(1);
        state_nxt = ST_SHR;
      end
      ST_WNEW: begin
        wr_en          = 1'b1;
        wr_addr        = pos_r[IDX_W-1:0];
        wr_data.base   = where_r;
        wr_data.length = item_r.seg_length;
        cnt_nxt        = cnt_r + CNT_W'(1);
        state_nxt      = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_item_nxt.status      = status_r;
          out_item_nxt.placed_base = where_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
      region_base_r   <= '0;
      region_length_r <= '0;
      page_shift_r    <= aafsp_pkg::PAGE_SHIFT_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aafsp_pkg::CFG_REGION_BASE:   region_base_r   <= cfg_data;
          aafsp_pkg::CFG_REGION_LENGTH: region_length_r <= cfg_data;
          aafsp_pkg::CFG_PAGE_SHIFT:    page_shift_r    <= cfg_data[aafsp_pkg::SHIFT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    where_r    <= where_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    prev_r     <= prev_nxt;
    cand_r     <= cand_nxt;
    end_r      <= end_nxt;
    lim_r      <= lim_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/aafsp_checker.sv
// port-level checks for the segment placer, bound to the top level
module aafsp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input aafsp_pkg::in_item_t              in_item,
  input logic                             out_valid,
  input logic                             out_stall,
  input aafsp_pkg::out_item_t             out_item
);

  // a result held back keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // a refused placement reports base zero
  a_fail_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != aafsp_pkg::STATUS_PLACED) |-> out_item.placed_base == '0)
    else $error("nonzero base on a failed request");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == aafsp_pkg::STATUS_PLACED)
               || (out_item.status == aafsp_pkg::STATUS_ZERO_LEN)
               || (out_item.status == aafsp_pkg::STATUS_NO_SPACE)
               || (out_item.status == aafsp_pkg::STATUS_OVERLAP)
               || (out_item.status == aafsp_pkg::STATUS_FULL))
    else $error("unknown status code");

  // one item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before the first finished");

  // a zero-length request taken with the result register empty comes back as zero-length
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.seg_length == '0) && !out_valid |=> ##1
      out_valid && (out_item.status == aafsp_pkg::STATUS_ZERO_LEN))
    else $error("zero-length item not reported as such");

endmodule

bind aligned_first_fit_segment_placer aafsp_checker u_aafsp_checker (.*);
